### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for clocked checks with a reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle, disabled while reset is high
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication in the next cycle, disabled while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/apslp_pkg.sv
// ----------------------------------------------------------------------------
// apslp_pkg
// Types, constants and decode helpers for the keypad status line parser.
// ----------------------------------------------------------------------------
package apslp_pkg;

   localparam int unsigned CharWidth   = 8;
   localparam int unsigned PosWidth    = 7;
   localparam int unsigned FlagWidth   = 15;
   localparam int unsigned PatLen      = 9;
   localparam int unsigned LineLength  = 94;
   localparam int unsigned NoDelayBit  = 11;
   localparam int unsigned ReadyBit    = 0;
   localparam int unsigned AwayBit     = 1;
   localparam int unsigned StayBit     = 2;
   localparam int unsigned AlarmBit    = 8;
   localparam int unsigned ReqDataWidth = 8;
   localparam int unsigned RspDataWidth = 24;

   localparam logic [CharWidth-1:0] CharOpen = 8'h5B;   // '['
   localparam logic [CharWidth-1:0] CharOne  = 8'h31;   // '1'

   localparam logic [PosWidth-1:0] PosMax  = 7'd127;
   localparam logic [PosWidth-1:0] PosLast = 7'(LineLength - 1);

   // "*INSTANT*" and "*MAXIMUM*", oldest character first
   localparam logic [CharWidth-1:0] PatInstant [PatLen] = '{
      8'h2A, 8'h49, 8'h4E, 8'h53, 8'h54, 8'h41, 8'h4E, 8'h54, 8'h2A
   };
   localparam logic [CharWidth-1:0] PatMaximum [PatLen] = '{
      8'h2A, 8'h4D, 8'h41, 8'h58, 8'h49, 8'h4D, 8'h55, 8'h4D, 8'h2A
   };

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_BAD_START  = 2'd1,
      STATUS_BAD_LENGTH = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      PANEL_READY     = 3'd0,
      PANEL_STAY      = 3'd1,
      PANEL_INSTANT   = 3'd2,
      PANEL_AWAY      = 3'd3,
      PANEL_MAX       = 3'd4,
      PANEL_ALARM     = 3'd5,
      PANEL_NOT_READY = 3'd6
   } panel_type;

   // Flag bit selected by a line position; the beep count position has none
   function automatic logic [FlagWidth-1:0] flag_mask(input logic [PosWidth-1:0] pos);
      logic [FlagWidth-1:0] m;
      m = '0;
      if (pos >= 7'd1 && pos <= 7'd5) begin
         m = FlagWidth'(1) << (pos - 7'd1);
      end else if (pos >= 7'd7 && pos <= 7'd16) begin
         m = FlagWidth'(1) << (pos - 7'd2);
      end
      return m;
   endfunction

   function automatic panel_type decode_panel(input logic [FlagWidth-1:0] f);
      panel_type s;
      if (f[ReadyBit] && !f[AlarmBit]) begin
         s = PANEL_READY;
      end else if (f[StayBit] && !f[AlarmBit]) begin
         s = f[NoDelayBit] ? PANEL_INSTANT : PANEL_STAY;
      end else if (f[AwayBit] && !f[AlarmBit]) begin
         s = f[NoDelayBit] ? PANEL_MAX : PANEL_AWAY;
      end else if (f[AlarmBit]) begin
         s = PANEL_ALARM;
      end else begin
         s = PANEL_NOT_READY;
      end
      return s;
   endfunction

endpackage

### rtl/alarm_panel_status_line_parser_unit.sv
// Path: a transferred character is registered in the input register, parsed,
// and a line result is registered in the result register and presented on rsp_*.
// Throughput: one character per cycle, set by the single parse stage between
// the two registers, save while a line end waits on an unread result.
// Reset (synchronous, active high) empties both registers and clears the
// per-line state: position, start check, flags, match window and match mark.
// ----------------------------------------------------------------------------
// alarm_panel_status_line_parser_unit
// Parses a keypad status line character by character and reports the status
// code, the packed flags and the decoded panel state at the end of the line.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module alarm_panel_status_line_parser_unit (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   input  logic [apslp_pkg::ReqDataWidth-1:0]       req_tdata,  // [7:0] char_in
   input  logic                                     req_tlast,  // line_end
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   // [1:0] status_code, [4:2] panel_state, [19:5] flags, [23:20] zero
   output logic [apslp_pkg::RspDataWidth-1:0]       rsp_tdata
);

   localparam int unsigned WinLen = apslp_pkg::PatLen - 1;

   // input register
   logic                                 s1_valid_ff, s1_valid_in;
   logic [apslp_pkg::CharWidth-1:0]      s1_char_ff;
   logic                                 s1_last_ff;

   // per-line state
   logic [apslp_pkg::PosWidth-1:0]       pos_ff, pos_in;
   logic                                 start_ok_ff, start_ok_in;
   logic [apslp_pkg::FlagWidth-1:0]      flags_ff, flags_in;
   logic [apslp_pkg::CharWidth-1:0]      win_ff [WinLen];
   logic [apslp_pkg::CharWidth-1:0]      win_in [WinLen];
   logic                                 seen_ff, seen_in;

   // result register
   logic                                 rsp_valid_ff, rsp_valid_in;
   apslp_pkg::status_type                status_ff, status_in;
   apslp_pkg::panel_type                 panel_ff, panel_in;
   logic [apslp_pkg::FlagWidth-1:0]      rflags_ff, rflags_in;

   logic                                 s1_adv, s1_fire, out_free;
   logic [apslp_pkg::CharWidth-1:0]      cur_win [apslp_pkg::PatLen];
   logic                                 hit_instant, hit_maximum;
   logic                                 start_now, seen_now;
   logic [apslp_pkg::FlagWidth-1:0]      flags_now, flags_out;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   // characters that end no line never wait on the result side
   assign s1_adv     = !s1_last_ff || out_free;
   assign s1_fire    = s1_valid_ff && s1_adv;
   assign req_tready = !s1_valid_ff || s1_adv;
   assign s1_valid_in = (req_tvalid && req_tready) ? 1'b1 :
                        (s1_fire ? 1'b0 : s1_valid_ff);

   // window as it stands with the current character shifted in
   always_comb begin
      for (int i = 0; i < WinLen; i++) begin
         cur_win[i] = win_ff[i];
      end
      cur_win[WinLen] = s1_char_ff;
   end

   always_comb begin
      hit_instant = 1'b1;
      hit_maximum = 1'b1;
      for (int i = 0; i < apslp_pkg::PatLen; i++) begin
         if (cur_win[i] != apslp_pkg::PatInstant[i]) hit_instant = 1'b0;
         if (cur_win[i] != apslp_pkg::PatMaximum[i]) hit_maximum = 1'b0;
      end
   end

   assign start_now = (pos_ff == '0) ? (s1_char_ff == apslp_pkg::CharOpen) : start_ok_ff;
   assign seen_now  = seen_ff || hit_instant || hit_maximum;
   assign flags_now = flags_ff |
                      ((s1_char_ff == apslp_pkg::CharOne) ? apslp_pkg::flag_mask(pos_ff)
                                                          : '0);

   always_comb begin
      flags_out = flags_now;
      flags_out[apslp_pkg::NoDelayBit] = flags_now[apslp_pkg::NoDelayBit] | seen_now;
   end

   // next per-line state: advance on each parsed character, clear at line end
   always_comb begin
      pos_in      = pos_ff;
      start_ok_in = start_ok_ff;
      flags_in    = flags_ff;
      seen_in     = seen_ff;
      for (int i = 0; i < WinLen; i++) begin
         win_in[i] = win_ff[i];
      end
      if (s1_fire) begin
         if (s1_last_ff) begin
            pos_in      = '0;
            start_ok_in = 1'b0;
            flags_in    = '0;
            seen_in     = 1'b0;
            for (int i = 0; i < WinLen; i++) begin
               win_in[i] = '0;
            end
         end else begin
            pos_in      = (pos_ff == apslp_pkg::PosMax) ? pos_ff : pos_ff + 7'd1;
            start_ok_in = start_now;
            flags_in    = flags_now;
            seen_in     = seen_now;
            for (int i = 0; i < WinLen; i++) begin
               win_in[i] = cur_win[i + 1];
            end
         end
      end
   end

   // result for the line-ending character
   always_comb begin
      status_in = status_ff;
      panel_in  = panel_ff;
      rflags_in = rflags_ff;
      if (s1_fire && s1_last_ff) begin
         if (!start_now) begin
            status_in = apslp_pkg::STATUS_BAD_START;
            panel_in  = apslp_pkg::PANEL_READY;
            rflags_in = '0;
         end else if (pos_ff != apslp_pkg::PosLast) begin
            status_in = apslp_pkg::STATUS_BAD_LENGTH;
            panel_in  = apslp_pkg::PANEL_READY;
            rflags_in = '0;
         end else begin
            status_in = apslp_pkg::STATUS_OK;
            panel_in  = apslp_pkg::decode_panel(flags_out);
            rflags_in = flags_out;
         end
      end
   end

   assign rsp_valid_in = (s1_fire && s1_last_ff) ? 1'b1 :
                         (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pos_ff       <= '0;
         start_ok_ff  <= 1'b0;
         flags_ff     <= '0;
         seen_ff      <= 1'b0;
         for (int i = 0; i < WinLen; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         pos_ff       <= pos_in;
         start_ok_ff  <= start_ok_in;
         flags_ff     <= flags_in;
         seen_ff      <= seen_in;
         for (int i = 0; i < WinLen; i++) begin
            win_ff[i] <= win_in[i];
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_char_ff <= req_tdata[7:0];
         s1_last_ff <= req_tlast;
      end
      status_ff <= status_in;
      panel_ff  <= panel_in;
      rflags_ff <= rflags_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rflags_ff, panel_ff, status_ff};

   `ASSERT_SAME(a_err_zero, clock, reset,
      rsp_valid_ff && status_ff != apslp_pkg::STATUS_OK,
      rflags_ff == '0 && panel_ff == apslp_pkg::PANEL_READY,
      "error result carries nonzero flags or state")
   `ASSERT_NEXT(a_line_clear, clock, reset, s1_fire && s1_last_ff,
      pos_ff == '0 && !seen_ff && flags_ff == '0 && !start_ok_ff,
      "per-line state not cleared after line end")
   `ASSERT_NEXT(a_pos_step, clock, reset, s1_fire && !s1_last_ff,
      pos_ff == apslp_pkg::PosMax || pos_ff == $past(pos_ff) + 7'd1,
      "character position did not advance")
   `ASSERT_SAME(a_ok_state, clock, reset,
      rsp_valid_ff && status_ff == apslp_pkg::STATUS_OK,
      rflags_ff[apslp_pkg::AlarmBit] == (panel_ff == apslp_pkg::PANEL_ALARM),
      "alarm flag and panel state disagree")

endmodule

### tb/alarm_panel_status_line_parser_unit_test.sv
// ----------------------------------------------------------------------------
// alarm_panel_status_line_parser_unit_test
// Drives keypad status lines into the parser one character per transfer and
// checks every line result against a cycle-free model of the parser: start
// and length checks, flag capture, marker search, length saturation and the
// panel state priority, with and without random idling on both sides.
// ----------------------------------------------------------------------------
module alarm_panel_status_line_parser_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import apslp_pkg::*;

   typedef logic [CharWidth-1:0] char_q_type [$];

   typedef enum int {
      MARK_NONE,
      MARK_INSTANT,
      MARK_MAXIMUM,
      MARK_NEAR
   } marker_kind_type;

   typedef struct {
      status_type             status;
      panel_type              panel;
      logic [FlagWidth-1:0]   flags;
   } line_result_type;

   // oldest character in the top byte
   localparam logic [8*PatLen-1:0] MarkInstant = "*INSTANT*";
   localparam logic [8*PatLen-1:0] MarkMaximum = "*MAXIMUM*";

   logic                    clock;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [ReqDataWidth-1:0] req_tdata  = '0;   // [7:0] char_in
   logic                    req_tlast  = 1'b0; // line_end
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   // [1:0] status_code, [4:2] panel_state, [19:5] flags, [23:20] zero
   logic [RspDataWidth-1:0] rsp_tdata;

   int send_idle_pct = 11;
   int recv_idle_pct = 76;
   int chars_sent    = 0;
   int lines_closed  = 0;
   int error_count   = 0;

   // parser model state
   logic [PosWidth-1:0]    line_pos      = '0;
   logic                   line_start_ok = 1'b0;
   logic [FlagWidth-1:0]   line_flags    = '0;
   logic [8*PatLen-1:0]    char_window   = '0;
   logic                   marker_seen   = 1'b0;

   line_result_type pending_results [$];

   alarm_panel_status_line_parser_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("** alarm_panel_status_line_parser_unit: FAILED **");
      $finish;
   end

   always @(negedge clock) begin
      rsp_tready = ($urandom_range(99) >= recv_idle_pct);
   end

   // ----- model ------------------------------------------------------------

   function automatic panel_type panel_of(input logic [FlagWidth-1:0] f);
      logic quick;
      quick = f[NoDelayBit];
      if (f[AlarmBit]) return PANEL_ALARM;
      if (f[ReadyBit]) return PANEL_READY;
      if (f[StayBit])  return quick ? PANEL_INSTANT : PANEL_STAY;
      if (f[AwayBit])  return quick ? PANEL_MAX : PANEL_AWAY;
      return PANEL_NOT_READY;
   endfunction

   // line position that carries a given flag bit
   function automatic int flag_pos(input int bit_idx);
      return (bit_idx < 5) ? bit_idx + 1 : bit_idx + 2;
   endfunction

   task automatic parse_char(input logic [CharWidth-1:0] c, input logic last);
      logic [PosWidth:0]    line_len;
      logic [FlagWidth-1:0] f;
      line_result_type      res;
      if (line_pos == '0) line_start_ok = (c == CharOpen);
      // position 6 is the beep count and carries no flag
      if (line_pos >= 1 && line_pos <= 16 && line_pos != 6 && c == CharOne) begin
         line_flags[(line_pos < 6) ? line_pos - 1 : line_pos - 2] = 1'b1;
      end
      char_window = {char_window[8*PatLen-9:0], c};
      if (char_window == MarkInstant || char_window == MarkMaximum) marker_seen = 1'b1;
      line_len = {1'b0, line_pos} + 1'b1;
      if (line_pos != PosMax) line_pos = line_pos + 1'b1;
      if (last) begin
         f = line_flags;
         if (marker_seen) f[NoDelayBit] = 1'b1;
         res.flags = '0;
         res.panel = PANEL_READY;
         if (!line_start_ok) begin
            res.status = STATUS_BAD_START;
         end else if (line_len != LineLength) begin
            res.status = STATUS_BAD_LENGTH;
         end else begin
            res.status = STATUS_OK;
            res.panel  = panel_of(f);
            res.flags  = f;
         end
         pending_results.push_back(res);
         lines_closed++;
         line_pos      = '0;
         line_start_ok = 1'b0;
         line_flags    = '0;
         char_window   = '0;
         marker_seen   = 1'b0;
      end
   endtask

   // ----- result checker ---------------------------------------------------

   always @(posedge clock) begin : check_results
      line_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result %h, no line pending", $time, rsp_tdata);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata[1:0] != want.status || rsp_tdata[4:2] != want.panel ||
                rsp_tdata[19:5] != want.flags || rsp_tdata[23:20] != 4'd0) begin
               $display("%0t: expected %0d %0d %h pad 0, got %0d %0d %h pad %h",
                        $time, want.status, want.panel, want.flags,
                        rsp_tdata[1:0], rsp_tdata[4:2], rsp_tdata[19:5], rsp_tdata[23:20]);
               error_count++;
            end
         end
      end
   end

   // ----- stimulus helpers -------------------------------------------------

   // call at a falling edge; returns at the falling edge after the transfer
   task automatic send_char(input logic [CharWidth-1:0] c, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = c;
      req_tlast  = last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      parse_char(c, last);
      chars_sent++;
      @(negedge clock);
   endtask

   task automatic send_line(input char_q_type line);
      for (int i = 0; i < line.size(); i++) send_char(line[i], i == line.size() - 1);
   endtask

   task automatic wait_results_drained();
      req_tvalid = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   function automatic logic [CharWidth-1:0] random_char();
      if ($urandom_range(9) < 8) return CharWidth'($urandom_range(8'h7E, 8'h20));
      return CharWidth'($urandom_range(255));
   endfunction

   function automatic logic [CharWidth-1:0] random_non_open();
      logic [CharWidth-1:0] c;
      do c = CharWidth'($urandom_range(255)); while (c == CharOpen);
      return c;
   endfunction

   function automatic char_q_type fit_length(input char_q_type line, input int len);
      while (line.size() > len) void'(line.pop_back());
      while (line.size() < len) line.push_back(random_char());
      return line;
   endfunction

   // well-formed line; at < 0 places the marker at random
   function automatic char_q_type make_status_line(input int flag_pct,
                                                   input marker_kind_type mark,
                                                   input int at);
      char_q_type          line;
      logic [8*PatLen-1:0] pat;
      int                  k;
      line = {};
      line.push_back(CharOpen);
      for (k = 1; k < LineLength; k++) begin
         if (k <= 16) begin
            if ($urandom_range(99) < flag_pct) line.push_back(CharOne);
            else if ($urandom_range(9) == 0) line.push_back(random_char());
            else line.push_back("0");
         end else begin
            line.push_back(random_char());
         end
      end
      if (mark != MARK_NONE) begin
         pat = (mark == MARK_MAXIMUM) ? MarkMaximum : MarkInstant;
         if (mark == MARK_NEAR) begin
            k = $urandom_range(PatLen - 1);
            pat[8*(PatLen-1-k) +: 8] = pat[8*(PatLen-1-k) +: 8] ^ (8'd1 << $urandom_range(7));
         end
         if (at < 0) at = $urandom_range(LineLength - PatLen, 1);
         for (k = 0; k < PatLen; k++) line[at+k] = pat[8*(PatLen-1-k) +: 8];
      end
      return line;
   endfunction

   // ----- tests ------------------------------------------------------------

   task automatic test_short_lines();
      send_line('{8'h00});
      send_line('{8'hFF});
      send_line('{CharOpen});
      send_line('{CharOpen, CharOne});
      send_line('{8'h5A});
      send_line('{8'h5C});
      send_line('{CharOne, CharOpen});
      send_line('{"*", "I", "N", "S", "T", "A", "N", "T", "*"});
   endtask

   task automatic test_line_lengths();
      char_q_type line;
      int         lens [4] = '{LineLength - 1, LineLength + 1, PosMax + 1, 150};
      foreach (lens[i]) begin
         line = make_status_line(50, MARK_NONE, -1);
         send_line(fit_length(line, lens[i]));
      end
      // right length, wrong opening character
      line = make_status_line(100, MARK_INSTANT, -1);
      line[0] = random_non_open();
      send_line(line);
   endtask

   task automatic test_panel_priority();
      char_q_type           line;
      logic [FlagWidth-1:0] masks [9];
      marker_kind_type      marks [9];
      masks = '{15'h0001, 15'h0101, 15'h0004, 15'h0004, 15'h0002,
                15'h0802, 15'h0100, 15'h0000, 15'h0806};
      marks = '{MARK_NONE, MARK_NONE, MARK_NONE, MARK_INSTANT, MARK_NONE,
                MARK_NONE, MARK_NONE, MARK_NONE, MARK_NONE};
      foreach (masks[i]) begin
         line = make_status_line(0, marks[i], 20);
         for (int b = 0; b < FlagWidth; b++) begin
            if (masks[i][b]) line[flag_pos(b)] = CharOne;
            else line[flag_pos(b)] = "0";
         end
         // a '1' on the beep count must not show up anywhere
         line[6] = CharOne;
         send_line(line);
      end
   endtask

   task automatic test_markers();
      char_q_type line;
      send_line(make_status_line(50, MARK_INSTANT, 1));
      send_line(make_status_line(50, MARK_MAXIMUM, LineLength - PatLen));
      send_line(make_status_line(50, MARK_NEAR, -1));
      send_line(make_status_line(100, MARK_MAXIMUM, 40));
      // line end clears the window: the tail of one line cannot finish a marker
      line = make_status_line(0, MARK_NONE, -1);
      line[LineLength-4] = "*";
      line[LineLength-3] = "I";
      line[LineLength-2] = "N";
      line[LineLength-1] = "S";
      send_line(line);
      send_line('{"T", "A", "N", "T", "*"});
   endtask

   task automatic test_random_traffic(input int item_goal, input int result_goal);
      char_q_type      line;
      int              first_item;
      int              first_result;
      int              kind;
      int              pcts [5] = '{0, 15, 50, 85, 100};
      marker_kind_type mark;
      first_item   = chars_sent;
      first_result = lines_closed;
      while (chars_sent - first_item < item_goal || lines_closed - first_result < result_goal) begin
         kind = $urandom_range(99);
         mark = marker_kind_type'($urandom_range(3));
         line = make_status_line(pcts[$urandom_range(4)], mark, -1);
         if (kind < 45) begin
            // well-formed, keep as built
         end else if (kind < 60) begin
            line[0] = random_non_open();
            line = fit_length(line, $urandom_range(100, 1));
         end else if (kind < 80) begin
            line = fit_length(line, $urandom_range(130, 1));
         end else if (kind < 86) begin
            line = fit_length(line, $urandom_range(170, PosMax + 1));
         end else begin
            line = {};
            repeat ($urandom_range(40, 1)) line.push_back(CharWidth'($urandom_range(255)));
         end
         send_line(line);
      end
   endtask

   // ----- sequence ---------------------------------------------------------

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_idle_pct = 11;
      recv_idle_pct = 76;
      test_short_lines();
      test_line_lengths();
      test_panel_priority();
      wait_results_drained();

      send_idle_pct = 76;
      recv_idle_pct = 11;
      test_markers();
      test_random_traffic(30, 0);
      wait_results_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_traffic(30, 0);

      wait_results_drained();
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("** alarm_panel_status_line_parser_unit: PASSED **");
      end else begin
         $display("** alarm_panel_status_line_parser_unit: FAILED **");
      end
      $finish;
   end

endmodule
